@@ src/pgm_stream_histogram_macros.svh @@
// assertion macros shared by the histogram rtl
`ifndef PGM_STREAM_HISTOGRAM_MACROS_SVH
`define PGM_STREAM_HISTOGRAM_MACROS_SVH

// property holds at every clock edge outside reset
`define PGM_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequent holds in the cycle after the antecedent
`define PGM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ src/pgm_hist_pkg.sv @@
// types, constants and helpers for the pgm histogram block
package pgm_hist_pkg;

  localparam int NUM_BINS    = 256;
  localparam int BIN_AW      = $clog2(NUM_BINS);
  localparam int MAXVAL_SKIP = 4;
  localparam int DIM_W       = 16;
  localparam int COUNT_W     = 32;
  localparam int OUT_W       = 72;

  localparam logic [7:0] MAGIC_P    = 8'h50;
  localparam logic [7:0] MAGIC_5    = 8'h35;
  localparam logic [7:0] CH_SPACE   = 8'h20;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_DIGIT0  = 8'h30;
  localparam logic [7:0] CH_DIGIT9  = 8'h39;

  typedef enum logic [1:0] {
    KIND_BYTE  = 2'd0,
    KIND_READ  = 2'd1,
    KIND_CLEAR = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    ST_HEADER   = 2'd0,
    ST_COUNTING = 2'd1,
    ST_DONE     = 2'd2,
    ST_BAD      = 2'd3
  } status_t;

  // header parser result for the item being accepted
  typedef struct packed {
    logic               count_en;
    status_t            status;
    logic [DIM_W-1:0]   width;
    logic [DIM_W-1:0]   height;
  } parse_res_t;

  // decimal digit accumulate, saturating at the dimension maximum
  function automatic logic [DIM_W-1:0] add_digit(input logic [DIM_W-1:0] acc,
                                                 input logic [7:0] b);
    logic [DIM_W+3:0] v;
    v = (DIM_W+4)'(acc) * (DIM_W+4)'(10) + (DIM_W+4)'(b[3:0]);
    return (v > (DIM_W+4)'({DIM_W{1'b1}})) ? {DIM_W{1'b1}} : v[DIM_W-1:0];
  endfunction

endpackage

@@ src/pgm_stream_histogram.sv @@
// top level of the pgm p5 pixel histogram
//
//  channel  | direction | payload
//  ---------+-----------+------------------------------------------------
//  in_      | slave     | tuser kind, tdata file byte or bin index
//  out_     | master    | tdata status, width, height, bin count
//
// one item per cycle while out_ is not stalled; each result is registered in stage one
// and then in the output register; the bin ram's registered read feeds stage one
// bin counts live in one 256 x 32 ram; read-modify-write happens in stage one
// with a one-entry forward from the write of the same cycle as the read
// a new image clears 256 per-bin valid flops at once, no clearing pass
// rst_n is synchronous; a stall on out_ holds stage one and then in_tready
`include "pgm_stream_histogram_macros.svh"

module pgm_stream_histogram (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_tvalid,
  output logic                       in_tready,
  input  logic [7:0]                 in_tdata,   // [7:0] value
  input  logic [1:0]                 in_tuser,   // [1:0] kind
  output logic                       out_tvalid,
  input  logic                       out_tready,
  output logic [pgm_hist_pkg::OUT_W-1:0] out_tdata
  // out_tdata: [1:0] status, [17:2] image_width, [33:18] image_height,
  //            [65:34] bin_count, [71:66] zero
);
  import pgm_hist_pkg::*;

  // input side
  logic                 in_fire;
  logic                 clr_fire;
  parse_res_t           pres;

  // stage one: ram data is back, bin is updated
  logic                 s1_valid_r, s1_valid_nxt;
  logic                 s1_inc_r;
  logic                 s1_rd_r;
  logic [BIN_AW-1:0]    s1_addr_r;
  logic                 s1_bvalid_r;
  logic                 s1_fwd_hit_r;
  logic [COUNT_W-1:0]   s1_fwd_data_r;
  status_t              s1_status_r;
  logic [DIM_W-1:0]     s1_width_r;
  logic [DIM_W-1:0]     s1_height_r;
  logic                 s1_go;
  logic                 s1_stall;

  // bin storage
  logic [NUM_BINS-1:0]  bin_valid_r, bin_valid_nxt;
  logic [COUNT_W-1:0]   ram_q;
  logic [COUNT_W-1:0]   cur_count;
  logic [COUNT_W-1:0]   wr_data;
  logic                 wr_en;

  // output register
  logic                 out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0]     out_data_r;

  assign in_fire   = in_tvalid && in_tready;
  assign clr_fire  = in_fire && (in_tuser == KIND_CLEAR);
  assign s1_go     = s1_valid_r && (!out_valid_r || out_tready);
  assign s1_stall  = s1_valid_r && !s1_go;
  assign in_tready = !s1_valid_r || s1_go;

  pgm_hist_parse u_parse (
    .clk        (clk),
    .rst_n      (rst_n),
    .item_fire  (in_fire),
    .item_kind  (in_tuser),
    .item_value (in_tdata),
    .res        (pres)
  );

  // bin count: forwarded write first, then ram word if the bin is live
  always_comb begin
    if (s1_fwd_hit_r) begin
      cur_count = s1_fwd_data_r;
    end else if (s1_bvalid_r) begin
      cur_count = ram_q;
    end else begin
      cur_count = '0;
    end
  end

  assign wr_en   = s1_go && s1_inc_r;
  assign wr_data = (&cur_count) ? cur_count : cur_count + COUNT_W'(1);

  pgm_hist_ram #(
    .WIDTH (COUNT_W),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk   (clk),
    .we    (wr_en),
    .waddr (s1_addr_r),
    .wdata (wr_data),
    .re    (in_fire),
    .raddr (in_tdata[BIN_AW-1:0]),
    .rdata (ram_q)
  );

  // a new image wins over a write from an older pixel in the same cycle
  always_comb begin
    bin_valid_nxt = bin_valid_r;
    if (clr_fire) begin
      bin_valid_nxt = '0;
    end else if (wr_en) begin
      bin_valid_nxt[s1_addr_r] = 1'b1;
    end
  end

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_fire) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_go) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (s1_go) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      bin_valid_r <= '0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
      bin_valid_r <= bin_valid_nxt;
    end
  end

  // stage one payload, captured with the transfer
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_inc_r      <= pres.count_en;
      s1_rd_r       <= (in_tuser == KIND_READ);
      s1_addr_r     <= in_tdata[BIN_AW-1:0];
      s1_bvalid_r   <= bin_valid_r[in_tdata[BIN_AW-1:0]];
      // the ram read of this cycle misses a write landing in the same cycle
      s1_fwd_hit_r  <= wr_en && (s1_addr_r == in_tdata[BIN_AW-1:0]);
      s1_fwd_data_r <= wr_data;
      s1_status_r   <= pres.status;
      s1_width_r    <= pres.width;
      s1_height_r   <= pres.height;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      out_data_r <= {6'b0,
                     (s1_rd_r ? cur_count : COUNT_W'(0)),
                     s1_height_r,
                     s1_width_r,
                     s1_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  `PGM_ASSERT(a_write_on_advance, clk, rst_n, wr_en |-> s1_go, "bin write without advance")
  `PGM_ASSERT_NEXT(a_clear_flags, clk, rst_n, clr_fire, bin_valid_r == '0, "flags not cleared")
  `PGM_ASSERT_NEXT(a_stall_holds_ram, clk, rst_n, s1_stall, $stable(ram_q), "ram word lost")
  `PGM_ASSERT(a_inc_nonzero, clk, rst_n, wr_en |-> (wr_data != '0), "incremented bin reads zero")

endmodule

@@ src/pgm_hist_ram.sv @@
// generic simple dual port ram with registered read
module pgm_hist_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // read returns the old word on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/pgm_hist_parse.sv @@
// p5 header parser and pixel down-counter
module pgm_hist_parse (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    item_fire,
  input  logic [1:0]              item_kind,
  input  logic [7:0]              item_value,
  output pgm_hist_pkg::parse_res_t res
);
  import pgm_hist_pkg::*;

  typedef enum logic [7:0] {
    PH_MAGIC0 = 8'b0000_0001,
    PH_MAGIC1 = 8'b0000_0010,
    PH_SEP    = 8'b0000_0100,
    PH_WIDTH  = 8'b0000_1000,
    PH_HEIGHT = 8'b0001_0000,
    PH_MAXVAL = 8'b0010_0000,
    PH_COUNT  = 8'b0100_0000,
    PH_BAD    = 8'b1000_0000
  } phase_t;

  localparam logic [2:0] SKIP_INIT = 3'(MAXVAL_SKIP);

  phase_t               phase_r,  phase_nxt;
  logic [2:0]           skip_r,   skip_nxt;
  logic [DIM_W-1:0]     width_r,  width_nxt;
  logic [DIM_W-1:0]     height_r, height_nxt;
  logic [COUNT_W-1:0]   pixels_r, pixels_nxt;
  logic                 count_en;
  logic                 is_digit;

  assign is_digit = (item_value >= CH_DIGIT0) && (item_value <= CH_DIGIT9);

  always_comb begin
    logic [2:0] skip_dec;
    phase_nxt  = phase_r;
    skip_nxt   = skip_r;
    width_nxt  = width_r;
    height_nxt = height_r;
    pixels_nxt = pixels_r;
    count_en   = 1'b0;
    skip_dec   = (skip_r != 3'd0) ? skip_r - 3'd1 : skip_r;
    if (item_fire) begin
      priority if (item_kind == KIND_CLEAR) begin
        phase_nxt  = PH_MAGIC0;
        skip_nxt   = '0;
        width_nxt  = '0;
        height_nxt = '0;
        pixels_nxt = '0;
      end else if (item_kind == KIND_BYTE) begin
        unique case (phase_r)
          PH_MAGIC0: phase_nxt = (item_value == MAGIC_P) ? PH_MAGIC1 : PH_BAD;
          PH_MAGIC1: phase_nxt = (item_value == MAGIC_5) ? PH_SEP : PH_BAD;
          PH_SEP:    phase_nxt = PH_WIDTH;
          PH_WIDTH: begin
            if (item_value == CH_SPACE) begin
              phase_nxt = PH_HEIGHT;
            end else if (is_digit) begin
              width_nxt = add_digit(width_r, item_value);
            end
          end
          PH_HEIGHT: begin
            if (item_value == CH_NEWLINE) begin
              phase_nxt  = (SKIP_INIT == 3'd0) ? PH_COUNT : PH_MAXVAL;
              skip_nxt   = SKIP_INIT;
              pixels_nxt = COUNT_W'(width_r) * COUNT_W'(height_r);
            end else if (is_digit) begin
              height_nxt = add_digit(height_r, item_value);
            end
          end
          PH_MAXVAL: begin
            skip_nxt = skip_dec;
            if (skip_dec == 3'd0) begin
              phase_nxt = PH_COUNT;
            end
          end
          PH_COUNT: begin
            if (pixels_r != '0) begin
              count_en   = 1'b1;
              pixels_nxt = pixels_r - COUNT_W'(1);
            end
          end
          default: ;
        endcase
      end else begin
        // bin reads and the unused kind leave the parser alone
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r  <= PH_MAGIC0;
      skip_r   <= '0;
      width_r  <= '0;
      height_r <= '0;
      pixels_r <= '0;
    end else begin
      phase_r  <= phase_nxt;
      skip_r   <= skip_nxt;
      width_r  <= width_nxt;
      height_r <= height_nxt;
      pixels_r <= pixels_nxt;
    end
  end

  always_comb begin
    res.count_en = count_en;
    res.width    = width_nxt;
    res.height   = height_nxt;
    if (phase_nxt == PH_BAD) begin
      res.status = ST_BAD;
    end else if (phase_nxt == PH_COUNT) begin
      res.status = (pixels_nxt != '0) ? ST_COUNTING : ST_DONE;
    end else begin
      res.status = ST_HEADER;
    end
  end

endmodule
